// ===== rtl/core/tmc_pkg.sv =====
// shared types, codes and constants for the transform matrix composer
package tmc_pkg;

    // operation codes carried in the request
    typedef enum logic [2:0] {
        FUNC_IDENT  = 3'd0,
        FUNC_TRANS  = 3'd1,
        FUNC_SCALE  = 3'd2,
        FUNC_ROT_X  = 3'd3,
        FUNC_ROT_Y  = 3'd4,
        FUNC_ROT_Z  = 3'd5
    } func_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_ROT,
        ST_TRIG,
        ST_MAC,
        ST_DRAIN,
        ST_COPY,
        ST_EMIT
    } state_t;

    // angle constants in Q2.30 on a 36-bit signed word
    localparam int ANG_W = 36;
    localparam logic signed [ANG_W-1:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 36'sd6746518852;

    // cordic datapath width and start value
    localparam int CRD_W = 34;
    localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int MAX_STEPS = 24;

    // arctangent of 2^-i in Q2.30
    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 36'sd843314857;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043837;
            5'd3:  v = 36'sd133525159;
            5'd4:  v = 36'sd67021687;
            5'd5:  v = 36'sd33543516;
            5'd6:  v = 36'sd16775851;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194283;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048576;
            5'd11: v = 36'sd524288;
            5'd12: v = 36'sd262144;
            5'd13: v = 36'sd131072;
            5'd14: v = 36'sd65536;
            5'd15: v = 36'sd32768;
            5'd16: v = 36'sd16384;
            5'd17: v = 36'sd8192;
            5'd18: v = 36'sd4096;
            5'd19: v = 36'sd2048;
            5'd20: v = 36'sd1024;
            5'd21: v = 36'sd512;
            5'd22: v = 36'sd256;
            5'd23: v = 36'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/transform_matrix_composer_unit.sv =====
// top level of the 4x4 homogeneous transform matrix composer
//
// Keeps a 4x4 transform matrix in signed fixed point (FRAC_BITS fraction
// bits); translate, scale or rotate about x, y or z replaces it with stored
// times one elementary matrix, identity load with identity; other codes keep it.
// Input channel s_*: one request per handshake, accepted only while idle.
// Output channel m_*: 16 beats per request, the whole matrix row by row,
// with m_tlast on the sixteenth beat and m_tuser flagging saturation.
// Per request: rotations first wrap and fold the angle, then run CORDIC_STEPS
// steps (at most 24) in the shared cordic shift/add unit and a step that
// scales sine and cosine; translate, scale and rotate then run 64
// multiply-accumulates through one shared 32x32 multiplier, a pipeline
// drain and a copy step; every request ends with 16 output beats.
// Reset loads the identity matrix and empties the output register.
// A stalled receiver holds the output register; the sequencer waits on it
// and no beat is lost or repeated.
module transform_matrix_composer_unit #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[2:0], op_x[34:3], op_y[66:35], op_z[98:67], angle[118:99]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // row[1:0], col[3:2], value[35:4]
    output logic [39:0]  m_tdata,
    // saturated[0]
    output logic         m_tuser,
    output logic         m_tlast
);

    localparam int STEPS = (CORDIC_STEPS < tmc_pkg::MAX_STEPS) ? CORDIC_STEPS
                                                               : tmc_pkg::MAX_STEPS;
    localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);
    localparam int TRIG_SHIFT = 30 - FRAC_BITS;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam int ACC_W = 66;
    localparam logic signed [ACC_W-1:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -66'sd2147483648;

    // request fields
    logic [2:0]         in_func;
    logic signed [31:0] in_op_x, in_op_y, in_op_z;
    logic signed [19:0] in_angle;

    assign in_func  = s_tdata[2:0];
    assign in_op_x  = s_tdata[34:3];
    assign in_op_y  = s_tdata[66:35];
    assign in_op_z  = s_tdata[98:67];
    assign in_angle = s_tdata[118:99];

    tmc_pkg::state_t state_reg, state_next;

    logic               accept;
    logic [2:0]         func_reg;
    logic signed [31:0] opx_reg, opy_reg, opz_reg;

    // cordic registers
    logic signed [tmc_pkg::ANG_W-1:0] z_reg;
    logic signed [tmc_pkg::CRD_W-1:0] x_reg, y_reg;
    logic                             neg_reg;
    logic [4:0]                       it_reg;
    logic signed [31:0]               cos_reg, sin_reg;

    // matrix storage
    logic signed [31:0] cur_reg [16];
    logic signed [31:0] pbuf_reg [16];
    logic [15:0]        sat_reg;

    // mac sequencing and pipeline
    logic [5:0]               cnt_reg;
    logic                     drain_reg;
    logic                     mv_reg;
    logic [5:0]               mtag_reg;
    logic signed [63:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     av_reg;
    logic [3:0]               aidx_reg;

    logic [3:0] emit_reg;
    logic       out_free;

    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_tvalid | m_tready;

    // angle wrap and fold conditions
    logic wrap_hi, wrap_lo, fold_hi, fold_lo;
    assign wrap_hi = z_reg > tmc_pkg::ANG_PI;
    assign wrap_lo = z_reg < -tmc_pkg::ANG_PI;
    assign fold_hi = z_reg > tmc_pkg::ANG_HALF_PI;
    assign fold_lo = z_reg < -tmc_pkg::ANG_HALF_PI;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tmc_pkg::ST_IDLE: begin
                if (accept) begin
                    case (in_func)
                        tmc_pkg::FUNC_TRANS,
                        tmc_pkg::FUNC_SCALE: state_next = tmc_pkg::ST_MAC;
                        tmc_pkg::FUNC_ROT_X,
                        tmc_pkg::FUNC_ROT_Y,
                        tmc_pkg::FUNC_ROT_Z: state_next = tmc_pkg::ST_WRAP;
                        default:             state_next = tmc_pkg::ST_EMIT;
                    endcase
                end
            end
            tmc_pkg::ST_WRAP: begin
                if (!wrap_hi && !wrap_lo) state_next = tmc_pkg::ST_ROT;
            end
            tmc_pkg::ST_ROT: begin
                if (it_reg == LAST_STEP) state_next = tmc_pkg::ST_TRIG;
            end
            tmc_pkg::ST_TRIG:  state_next = tmc_pkg::ST_MAC;
            tmc_pkg::ST_MAC: begin
                if (cnt_reg == 6'd63) state_next = tmc_pkg::ST_DRAIN;
            end
            tmc_pkg::ST_DRAIN: begin
                if (drain_reg) state_next = tmc_pkg::ST_COPY;
            end
            tmc_pkg::ST_COPY:  state_next = tmc_pkg::ST_EMIT;
            tmc_pkg::ST_EMIT: begin
                if (out_free && emit_reg == 4'd15) state_next = tmc_pkg::ST_IDLE;
            end
            default: state_next = tmc_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == tmc_pkg::ST_IDLE);
    end

    // elementary matrix entry at row kk, column jj
    function automatic logic signed [31:0] elem(input logic [2:0] f,
                                                input logic [1:0] kk,
                                                input logic [1:0] jj,
                                                input logic signed [31:0] ox,
                                                input logic signed [31:0] oy,
                                                input logic signed [31:0] oz,
                                                input logic signed [31:0] c,
                                                input logic signed [31:0] s);
        logic [3:0]         idx;
        logic signed [31:0] v;
        idx = {kk, jj};
        v   = (kk == jj) ? ONE : 32'sd0;
        case (f)
            tmc_pkg::FUNC_TRANS: begin
                if (idx == 4'd3)  v = ox;
                if (idx == 4'd7)  v = oy;
                if (idx == 4'd11) v = oz;
            end
            tmc_pkg::FUNC_SCALE: begin
                if (idx == 4'd0)  v = ox;
                if (idx == 4'd5)  v = oy;
                if (idx == 4'd10) v = oz;
            end
            tmc_pkg::FUNC_ROT_X: begin
                if (idx == 4'd5 || idx == 4'd10) v = c;
                if (idx == 4'd6)  v = s;
                if (idx == 4'd9)  v = -s;
            end
            tmc_pkg::FUNC_ROT_Y: begin
                if (idx == 4'd0 || idx == 4'd10) v = c;
                if (idx == 4'd2)  v = -s;
                if (idx == 4'd8)  v = s;
            end
            tmc_pkg::FUNC_ROT_Z: begin
                if (idx == 4'd0 || idx == 4'd5) v = c;
                if (idx == 4'd1)  v = s;
                if (idx == 4'd4)  v = -s;
            end
            default: v = v;
        endcase
        return v;
    endfunction

    // single read port on the stored matrix
    logic [3:0]         rd_idx;
    logic signed [31:0] cur_rd;
    logic signed [31:0] e_rd;

    assign rd_idx = (state_reg == tmc_pkg::ST_EMIT) ? emit_reg
                                                    : {cnt_reg[5:4], cnt_reg[1:0]};
    assign cur_rd = cur_reg[rd_idx];
    assign e_rd   = elem(func_reg, cnt_reg[1:0], cnt_reg[3:2],
                         opx_reg, opy_reg, opz_reg, cos_reg, sin_reg);

    // shared cordic step
    logic signed [tmc_pkg::CRD_W-1:0] x_sh, y_sh, x_fin, y_fin;
    logic signed [tmc_pkg::ANG_W-1:0] atan_v;
    assign x_sh   = x_reg >>> it_reg;
    assign y_sh   = y_reg >>> it_reg;
    assign atan_v = tmc_pkg::atan_q30(it_reg);
    assign x_fin  = neg_reg ? -x_reg : x_reg;
    assign y_fin  = neg_reg ? -y_reg : y_reg;

    // truncate and saturate the finished sum
    logic signed [ACC_W-1:0] acc_sh;
    logic                    sat_hi, sat_lo;
    logic signed [31:0]      sat_val;
    assign acc_sh  = acc_reg >>> FRAC_BITS;
    assign sat_hi  = acc_sh > SAT_MAX;
    assign sat_lo  = acc_sh < SAT_MIN;
    assign sat_val = sat_hi ? 32'sh7fffffff : (sat_lo ? 32'sh80000000 : acc_sh[31:0]);

    // sequencer, cordic and matrix registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tmc_pkg::ST_IDLE;
            for (int n = 0; n < 16; n++) begin
                cur_reg[n] <= (n % 5 == 0) ? ONE : 32'sd0;
            end
            sat_reg   <= '0;
            cnt_reg   <= '0;
            drain_reg <= 1'b0;
            emit_reg  <= '0;
            it_reg    <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                tmc_pkg::ST_IDLE: begin
                    if (accept) begin
                        func_reg <= in_func;
                        opx_reg  <= in_op_x;
                        opy_reg  <= in_op_y;
                        opz_reg  <= in_op_z;
                        z_reg    <= 36'(in_angle) <<< 14;
                        x_reg    <= tmc_pkg::CORDIC_GAIN;
                        y_reg    <= '0;
                        neg_reg  <= 1'b0;
                        it_reg   <= '0;
                        cnt_reg  <= '0;
                        emit_reg <= '0;
                        drain_reg <= 1'b0;
                        sat_reg  <= '0;
                        if (in_func == tmc_pkg::FUNC_IDENT) begin
                            for (int n = 0; n < 16; n++) begin
                                cur_reg[n] <= (n % 5 == 0) ? ONE : 32'sd0;
                            end
                        end
                    end
                end
                tmc_pkg::ST_WRAP: begin
                    if (wrap_hi) begin
                        z_reg <= z_reg - tmc_pkg::ANG_TWO_PI;
                    end else if (wrap_lo) begin
                        z_reg <= z_reg + tmc_pkg::ANG_TWO_PI;
                    end else if (fold_hi) begin
                        z_reg   <= z_reg - tmc_pkg::ANG_PI;
                        neg_reg <= 1'b1;
                    end else if (fold_lo) begin
                        z_reg   <= z_reg + tmc_pkg::ANG_PI;
                        neg_reg <= 1'b1;
                    end
                end
                tmc_pkg::ST_ROT: begin
                    if (z_reg >= 0) begin
                        x_reg <= x_reg - y_sh;
                        y_reg <= y_reg + x_sh;
                        z_reg <= z_reg - atan_v;
                    end else begin
                        x_reg <= x_reg + y_sh;
                        y_reg <= y_reg - x_sh;
                        z_reg <= z_reg + atan_v;
                    end
                    it_reg <= it_reg + 5'd1;
                end
                tmc_pkg::ST_TRIG: begin
                    cos_reg <= 32'(x_fin >>> TRIG_SHIFT);
                    sin_reg <= 32'(y_fin >>> TRIG_SHIFT);
                end
                tmc_pkg::ST_MAC: begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
                tmc_pkg::ST_DRAIN: begin
                    drain_reg <= 1'b1;
                end
                tmc_pkg::ST_COPY: begin
                    for (int n = 0; n < 16; n++) begin
                        cur_reg[n] <= pbuf_reg[n];
                    end
                end
                tmc_pkg::ST_EMIT: begin
                    if (out_free) emit_reg <= emit_reg + 4'd1;
                end
                default: begin
                    cnt_reg <= cnt_reg;
                end
            endcase
            // saturation flag of each finished entry
            if (av_reg) sat_reg[aidx_reg] <= sat_hi | sat_lo;
        end
    end

    // multiply-accumulate pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
            av_reg <= 1'b0;
        end else begin
            mv_reg   <= (state_reg == tmc_pkg::ST_MAC);
            mtag_reg <= cnt_reg;
            prod_reg <= cur_rd * e_rd;
            av_reg   <= mv_reg && (mtag_reg[1:0] == 2'd3);
            aidx_reg <= mtag_reg[5:2];
            if (mv_reg) begin
                acc_reg <= ((mtag_reg[1:0] == 2'd0) ? '0 : acc_reg) + ACC_W'(prod_reg);
            end
            if (av_reg) pbuf_reg[aidx_reg] <= sat_val;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (state_reg == tmc_pkg::ST_EMIT && out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, cur_rd, emit_reg[1:0], emit_reg[3:2]};
            m_tuser  <= sat_reg[emit_reg];
            m_tlast  <= (emit_reg == 4'd15);
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

endmodule

// ===== tb/transform_matrix_composer_unit_tb.sv =====
// self-checking testbench for the transform matrix composer, driver and monitor with a predictor
`timescale 1ns / 1ps

module transform_matrix_composer_unit_tb;

    localparam int FRAC = 16;
    localparam int STEPS = 16;
    localparam int N_RANDOM = 164;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [19:0] angle;
        logic [31:0] op_z;
        logic [31:0] op_y;
        logic [31:0] op_x;
        logic [2:0]  func;
    } req_t;

    typedef struct {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic        sat;
        logic        last;
    } entry_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    req_t   pending_reqs[$];
    entry_t expected_entries[$];
    longint model_mat[16];
    int     error_count = 0;
    longint cycle_count = 0;
    bit     stim_done = 0;
    bit     idle_free = 0;
    int     hold_cycles = 0;
    bit     hold_armed = 0;
    logic   s_tready_seen = 1'b0;

    transform_matrix_composer_unit #(.FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // arithmetic shift right with floor rounding
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_entry(int i);
        longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
            262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128};
        return t[i];
    endfunction

    // cosine and sine of a signed Q4.16 angle, cordic as the block does it
    task automatic trig_of(input logic [19:0] ang, output longint c, output longint s);
        longint z, x, y, nx;
        bit neg;
        z = longint'($signed(ang)) * 16384;
        x = 652032874;
        y = 0;
        neg = 0;
        if (z > tmc_pkg::ANG_PI) z -= tmc_pkg::ANG_TWO_PI;
        if (z > tmc_pkg::ANG_PI) z -= tmc_pkg::ANG_TWO_PI;
        if (z < -tmc_pkg::ANG_PI) z += tmc_pkg::ANG_TWO_PI;
        if (z < -tmc_pkg::ANG_PI) z += tmc_pkg::ANG_TWO_PI;
        if (z > tmc_pkg::ANG_HALF_PI) begin
            z -= tmc_pkg::ANG_PI; neg = 1;
        end else if (z < -tmc_pkg::ANG_HALF_PI) begin
            z += tmc_pkg::ANG_PI; neg = 1;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= atan_entry(i);
            end else begin
                nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z += atan_entry(i);
            end
            x = nx;
        end
        if (neg) begin
            x = -x; y = -y;
        end
        c = shr_floor(x, 30 - FRAC);
        s = shr_floor(y, 30 - FRAC);
    endtask

    // apply one request to the model matrix and queue its 16 entries
    task automatic compose_request(input req_t r);
        longint e[16];
        longint prod[16];
        bit     sat[16];
        longint c, s, hi, lo, p, ph, acc;
        bit     do_mul;
        entry_t ent;
        for (int i = 0; i < 16; i++) begin
            e[i] = (i % 5 == 0) ? (longint'(1) << FRAC) : 0;
            sat[i] = 0;
        end
        do_mul = 1;
        case (r.func)
            tmc_pkg::FUNC_IDENT: begin
                for (int i = 0; i < 16; i++) model_mat[i] = e[i];
                do_mul = 0;
            end
            tmc_pkg::FUNC_TRANS: begin
                e[3] = $signed(r.op_x); e[7] = $signed(r.op_y); e[11] = $signed(r.op_z);
            end
            tmc_pkg::FUNC_SCALE: begin
                e[0] = $signed(r.op_x); e[5] = $signed(r.op_y); e[10] = $signed(r.op_z);
            end
            tmc_pkg::FUNC_ROT_X: begin
                trig_of(r.angle, c, s);
                e[5] = c; e[6] = s; e[9] = -s; e[10] = c;
            end
            tmc_pkg::FUNC_ROT_Y: begin
                trig_of(r.angle, c, s);
                e[0] = c; e[2] = -s; e[8] = s; e[10] = c;
            end
            tmc_pkg::FUNC_ROT_Z: begin
                trig_of(r.angle, c, s);
                e[0] = c; e[1] = s; e[4] = -s; e[5] = c;
            end
            default: do_mul = 0;
        endcase
        if (do_mul) begin
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++) begin
                    hi = 0; lo = 0;
                    for (int k = 0; k < 4; k++) begin
                        p = model_mat[i*4+k] * e[k*4+j];
                        ph = shr_floor(p, FRAC);
                        hi += ph;
                        lo += p - (ph << FRAC);
                    end
                    acc = hi + shr_floor(lo, FRAC);
                    if (acc > 64'sd2147483647) begin
                        acc = 64'sd2147483647; sat[i*4+j] = 1;
                    end
                    if (acc < -64'sd2147483648) begin
                        acc = -64'sd2147483648; sat[i*4+j] = 1;
                    end
                    prod[i*4+j] = acc;
                end
            for (int i = 0; i < 16; i++) model_mat[i] = prod[i];
        end
        for (int i = 0; i < 16; i++) begin
            ent.row = i[3:2];
            ent.col = i[1:0];
            ent.value = model_mat[i][31:0];
            ent.sat = sat[i];
            ent.last = (i == 15);
            expected_entries.push_back(ent);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic req_t make_req(logic [2:0] f, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, logic [19:0] a);
        req_t r;
        r.func = f; r.op_x = x; r.op_y = y; r.op_z = z; r.angle = a;
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 262144)) - 131072);
            2: return 32'h0001_0000 + 32'($urandom_range(0, 8192)) - 32'd4096;
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($urandom_range(0, 65535)) - 32'd32768;
        endcase
    endfunction

    // stimulus: directed corners, then random sequences
    initial begin
        logic [2:0] f;
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_IDENT, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_TRANS, 32'h7fff_ffff, 32'h8000_0000,
                                        32'h0001_0000, 0));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_SCALE, 32'h7fff_ffff, 32'h8000_0000,
                                        32'hffff_ffff, 0));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_SCALE, 32'h7fff_ffff, 32'h7fff_ffff,
                                        0, 0));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_IDENT, 32'hffff_ffff, 32'hffff_ffff,
                                        32'hffff_ffff, 20'hfffff));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_ROT_X, 0, 0, 0, 20'd411775));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_ROT_Y, 0, 0, 0, -20'sd411775));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_ROT_Z, 0, 0, 0, 20'h7ffff));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_ROT_X, 0, 0, 0, 20'h80000));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_ROT_Y, 0, 0, 0, 20'd102944));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_ROT_Z, 0, 0, 0, 20'd205887));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_ROT_Z, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd6, 32'h1234_5678, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd7, 0, 32'hffff_ffff, 0, 20'hfffff));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_TRANS, 32'h0002_0000, 32'hfffe_0000,
                                        32'h0, 0));
        pending_reqs.push_back(make_req(tmc_pkg::FUNC_IDENT, 0, 0, 0, 0));
        for (int n = 0; n < N_RANDOM; n++) begin
            // mostly real transforms, occasional identity and unused codes
            if ($urandom_range(0, 19) == 0) f = tmc_pkg::FUNC_IDENT;
            else if ($urandom_range(0, 24) == 0) f = 3'($urandom_range(6, 7));
            else f = 3'($urandom_range(1, 5));
            pending_reqs.push_back(make_req(f, rand_operand(), rand_operand(), rand_operand(),
                                            20'($urandom)));
        end
        stim_done = 1;
    end

    // reset and idle values
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // no idling for a stretch in the middle of the run
    always @(posedge aclk)
        idle_free <= (cycle_count > 8000 && cycle_count < 16000);

    // driver: present the next request on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready_seen) begin
                if (pending_reqs.size() > 0 && (idle_free || $urandom_range(0, 99) >= 15)) begin
                    s_tdata <= {1'b0, pending_reqs.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else if (!s_tvalid && pending_reqs.size() > 0
                         && (idle_free || $urandom_range(0, 99) >= 15)) begin
                s_tdata <= {1'b0, pending_reqs.pop_front()};
                s_tvalid <= 1'b1;
            end
        end
    end

    // sender side handshake seen at the rising edge; predict on acceptance
    always @(posedge aclk) begin
        s_tready_seen <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            compose_request(req_t'(s_tdata[118:0]));
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!hold_armed && cycle_count > 3000) begin
                hold_armed <= 1'b1;
                hold_cycles <= 1500;
                m_tready <= 1'b0;
            end else if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= idle_free || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        entry_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_entries.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[35:4], 32'd0);
            end else begin
                want = expected_entries.pop_front();
                if (m_tdata[1:0] !== want.row)
                    report_mismatch("row", 32'(m_tdata[1:0]), 32'(want.row));
                if (m_tdata[3:2] !== want.col)
                    report_mismatch("col", 32'(m_tdata[3:2]), 32'(want.col));
                if (m_tdata[35:4] !== want.value)
                    report_mismatch("value", m_tdata[35:4], want.value);
                if (m_tuser !== want.sat)
                    report_mismatch("saturated", 32'(m_tuser), 32'(want.sat));
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // timeout
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // end of run
    initial begin
        for (int i = 0; i < 16; i++) model_mat[i] = (i % 5 == 0) ? (longint'(1) << FRAC) : 0;
        @(posedge aresetn);
        wait (stim_done && pending_reqs.size() == 0);
        @(posedge aclk);
        while (s_tvalid || expected_entries.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
